/* sv/rmed_pkg.sv */
`default_nettype none

package rmed_pkg;

    // store geometry
    localparam int CAPACITY = 1024;
    localparam int DATA_W   = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // reduction tree geometry: groups of cells folded in the first level
    localparam int GRP  = 32;
    localparam int NGRP = (CAPACITY + GRP - 1) / GRP;

    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic [IDX_W-1:0]         t_idx;
    typedef logic [CNT_W-1:0]         t_cnt;

    typedef enum logic {
        ACT_INSERT = 1'b0,
        ACT_DELETE = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_ABSENT = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        logic    cmp_en;
        logic    upd_en;
        t_action action;
        t_data   value;
        t_cnt    count;
        t_idx    lo_idx;
        t_idx    hi_idx;
    } t_ctl;

    // what each cell hands to the reduction tree
    typedef struct packed {
        logic  eq;
        t_data lo;
        t_data hi;
    } t_lane;

endpackage

`default_nettype wire

/* sv/rmed_cell.sv */
`default_nettype none

module rmed_cell (
    input  wire logic          i_clk,
    input  wire rmed_pkg::t_idx i_idx,
    input  wire rmed_pkg::t_ctl i_ctl,
    input  wire logic          i_left_keep,
    input  wire rmed_pkg::t_data i_left_val,
    input  wire rmed_pkg::t_data i_right_val,
    output logic               o_keep,
    output rmed_pkg::t_data    o_val,
    output rmed_pkg::t_lane    o_lane
);

    rmed_pkg::t_data r_val;
    logic            r_keep;
    logic            r_eq;
    logic            in_use;
    logic            n_keep;
    logic            n_eq;
    rmed_pkg::t_data n_val;

    // cell holds a live entry when its index is below the count
    assign in_use = ({1'b0, i_idx} < i_ctl.count);

    // compare phase: does this entry stay in place
    always_comb begin
        n_eq = in_use && (r_val == i_ctl.value);
        case (i_ctl.action)
            rmed_pkg::ACT_INSERT: n_keep = in_use && (r_val <= i_ctl.value);
            rmed_pkg::ACT_DELETE: n_keep = in_use && (r_val < i_ctl.value);
            default:              n_keep = 1'b0;
        endcase
    end

    // update phase: stay, take the new value, or take a neighbor's entry
    always_comb begin
        n_val = r_val;
        case (i_ctl.action)
            rmed_pkg::ACT_INSERT: begin
                if (r_keep) begin
                    n_val = r_val;
                end else if (i_left_keep) begin
                    n_val = i_ctl.value;
                end else begin
                    n_val = i_left_val;
                end
            end
            rmed_pkg::ACT_DELETE: begin
                n_val = r_keep ? r_val : i_right_val;
            end
            default: n_val = r_val;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp_en) begin
            r_keep <= n_keep;
            r_eq   <= n_eq;
        end
        if (i_ctl.upd_en) begin
            r_val <= n_val;
        end
    end

    assign o_keep    = r_keep;
    assign o_val     = r_val;
    assign o_lane.eq = r_eq;
    assign o_lane.lo = (i_idx == i_ctl.lo_idx) ? r_val : '0;
    assign o_lane.hi = (i_idx == i_ctl.hi_idx) ? r_val : '0;

endmodule

`default_nettype wire

/* sv/rmed_tree.sv */
`default_nettype none

module rmed_tree (
    input  wire logic            i_clk,
    input  wire rmed_pkg::t_lane i_lanes [rmed_pkg::CAPACITY],
    output rmed_pkg::t_lane      o_sum
);

    rmed_pkg::t_lane r_grp [rmed_pkg::NGRP];
    rmed_pkg::t_lane n_grp [rmed_pkg::NGRP];
    rmed_pkg::t_lane r_sum;
    rmed_pkg::t_lane n_sum;

    // first level: or across each group of cells
    always_comb begin
        for (int g = 0; g < rmed_pkg::NGRP; g++) begin
            n_grp[g] = '0;
            for (int j = 0; j < rmed_pkg::GRP; j++) begin
                if (g * rmed_pkg::GRP + j < rmed_pkg::CAPACITY) begin
                    n_grp[g].eq = n_grp[g].eq | i_lanes[g * rmed_pkg::GRP + j].eq;
                    n_grp[g].lo = n_grp[g].lo | i_lanes[g * rmed_pkg::GRP + j].lo;
                    n_grp[g].hi = n_grp[g].hi | i_lanes[g * rmed_pkg::GRP + j].hi;
                end
            end
        end
    end

    // second level: or across the groups
    always_comb begin
        n_sum = '0;
        for (int g = 0; g < rmed_pkg::NGRP; g++) begin
            n_sum.eq = n_sum.eq | r_grp[g].eq;
            n_sum.lo = n_sum.lo | r_grp[g].lo;
            n_sum.hi = n_sum.hi | r_grp[g].hi;
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp <= n_grp;
        r_sum <= n_sum;
    end

    assign o_sum = r_sum;

endmodule

`default_nettype wire

/* sv/running_median_insert_delete.sv */
// channel | valid   | stall   | payload
// --------+---------+---------+-------------------------------------------
// in      | i_valid | o_stall | i_action, i_value
// out     | o_valid | i_stall | o_median, o_median_valid, o_status, o_count
//
// a beat taken in S_IDLE runs S_CMP (compare in the cell row), S_RED1 and S_RED2
// (or-tree for a match), S_UPD (shift), S_MED1 and S_MED2 (tree for the middle pair)
// and S_SUM (add); no new beat is taken until the sequencer is back in S_IDLE.
// reset (synchronous, active low) clears the count, the sequencer and o_valid only.
// o_stall is high while a beat is in flight, also while one waits in its add cycle
// behind a result that i_stall holds in the output register.
`default_nettype none

module running_median_insert_delete (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic                  i_action,
    input  wire logic signed [31:0]    i_value,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic signed [31:0]         o_median,
    output logic                       o_median_valid,
    output logic [1:0]                 o_status,
    output logic [10:0]                o_count
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_CMP  = 8'b0000_0010,
        S_RED1 = 8'b0000_0100,
        S_RED2 = 8'b0000_1000,
        S_UPD  = 8'b0001_0000,
        S_MED1 = 8'b0010_0000,
        S_MED2 = 8'b0100_0000,
        S_SUM  = 8'b1000_0000
    } t_state;

    t_state                  r_state;
    t_state                  n_state;
    rmed_pkg::t_action       r_action;
    rmed_pkg::t_data         r_value;
    rmed_pkg::t_cnt          r_count;
    rmed_pkg::t_cnt          n_count;
    rmed_pkg::t_status       r_status;
    rmed_pkg::t_status       n_status;
    logic                    r_out_valid;
    rmed_pkg::t_data         r_median;
    logic                    r_median_valid;
    rmed_pkg::t_status       r_out_status;
    rmed_pkg::t_cnt          r_out_count;

    rmed_pkg::t_ctl          ctl;
    rmed_pkg::t_lane         lanes [rmed_pkg::CAPACITY];
    rmed_pkg::t_lane         tree_sum;
    logic                    keep [rmed_pkg::CAPACITY];
    rmed_pkg::t_data         vals [rmed_pkg::CAPACITY];
    rmed_pkg::t_cnt          cnt_dec;
    logic                    full;
    logic                    apply;
    logic                    in_acc;
    logic                    out_free;
    logic signed [rmed_pkg::DATA_W:0] pair_sum;

    assign in_acc   = i_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_stall;
    assign full     = (r_count == rmed_pkg::CNT_W'(rmed_pkg::CAPACITY));
    assign cnt_dec  = r_count - rmed_pkg::CNT_W'(1);

    // store changes only for an insert with room or a delete that matched
    always_comb begin
        apply    = 1'b0;
        n_status = rmed_pkg::ST_OK;
        n_count  = r_count;
        case (r_action)
            rmed_pkg::ACT_INSERT: begin
                if (full) begin
                    n_status = rmed_pkg::ST_FULL;
                end else begin
                    apply   = 1'b1;
                    n_count = r_count + rmed_pkg::CNT_W'(1);
                end
            end
            rmed_pkg::ACT_DELETE: begin
                if (tree_sum.eq) begin
                    apply   = 1'b1;
                    n_count = cnt_dec;
                end else begin
                    n_status = rmed_pkg::ST_ABSENT;
                end
            end
            default: apply = 1'b0;
        endcase
    end

    // broadcast to the cell row
    always_comb begin
        ctl.cmp_en = (r_state == S_CMP);
        ctl.upd_en = (r_state == S_UPD) && apply;
        ctl.action = r_action;
        ctl.value  = r_value;
        ctl.count  = r_count;
        ctl.lo_idx = cnt_dec[rmed_pkg::CNT_W-1:1];
        ctl.hi_idx = r_count[rmed_pkg::CNT_W-1:1];
    end

    // row of cells, each inner cell linked to both neighbors
    for (genvar g = 0; g < rmed_pkg::CAPACITY; g++) begin : g_cell
        logic            left_keep;
        rmed_pkg::t_data left_val;
        rmed_pkg::t_data right_val;

        if (g == 0) begin : g_first
            assign left_keep = 1'b1;
            assign left_val  = vals[g];
        end else begin : g_mid
            assign left_keep = keep[g-1];
            assign left_val  = vals[g-1];
        end

        if (g == rmed_pkg::CAPACITY - 1) begin : g_last
            assign right_val = vals[g];
        end else begin : g_inner
            assign right_val = vals[g+1];
        end

        rmed_cell u_cell (
            .i_clk       (i_clk),
            .i_idx       (rmed_pkg::IDX_W'(g)),
            .i_ctl       (ctl),
            .i_left_keep (left_keep),
            .i_left_val  (left_val),
            .i_right_val (right_val),
            .o_keep      (keep[g]),
            .o_val       (vals[g]),
            .o_lane      (lanes[g])
        );
    end

    rmed_tree u_tree (
        .i_clk   (i_clk),
        .i_lanes (lanes),
        .o_sum   (tree_sum)
    );

    // middle pair mean, floor by arithmetic shift of the 33-bit sum
    assign pair_sum = {tree_sum.lo[rmed_pkg::DATA_W-1], tree_sum.lo}
                    + {tree_sum.hi[rmed_pkg::DATA_W-1], tree_sum.hi};

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  n_state = i_valid ? S_CMP : S_IDLE;
            S_CMP:   n_state = S_RED1;
            S_RED1:  n_state = S_RED2;
            S_RED2:  n_state = S_UPD;
            S_UPD:   n_state = S_MED1;
            S_MED1:  n_state = S_MED2;
            S_MED2:  n_state = S_SUM;
            S_SUM:   n_state = out_free ? S_IDLE : S_SUM;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_UPD) begin
                r_count <= n_count;
            end
            if (r_state == S_SUM && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // beat capture, status and output register
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_action <= rmed_pkg::t_action'(i_action);
            r_value  <= i_value;
        end
        if (r_state == S_UPD) begin
            r_status <= n_status;
        end
        if (r_state == S_SUM && out_free) begin
            r_median       <= (r_count != '0) ? pair_sum[rmed_pkg::DATA_W:1] : '0;
            r_median_valid <= (r_count != '0);
            r_out_status   <= r_status;
            r_out_count    <= r_count;
        end
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_median       = r_median;
    assign o_median_valid = r_median_valid;
    assign o_status       = r_out_status;
    assign o_count        = r_out_count;

endmodule

`default_nettype wire

/* sv/rmed_checker.sv */
`default_nettype none

module rmed_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_valid,
    input wire logic               i_stall,
    input wire logic signed [31:0] o_median,
    input wire logic               o_median_valid,
    input wire logic [1:0]         o_status,
    input wire logic [10:0]        o_count
);

    // a held result beat keeps its payload
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_median) && $stable(o_count))
        else $error("held result beat changed");

    // empty store reports a zero median and no valid flag
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_median_valid == (o_count != 11'd0)))
        else $error("median valid flag disagrees with count");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_median_valid |-> o_median == 32'sd0)
        else $error("median not zero on empty store");

    // full status only when the store is at capacity
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == rmed_pkg::ST_FULL |->
            o_count == 11'(rmed_pkg::CAPACITY))
        else $error("full status below capacity");

    // no result leaves the block right after reset
    assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat after reset");

endmodule

bind running_median_insert_delete rmed_checker u_rmed_checker (.*);

`default_nettype wire

/* dv/running_median_checker.sv */
`timescale 1ns / 1ps

module running_median_checker
    import rmed_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_stall,
    input  logic        i_action,
    input  t_data       i_value,
    input  logic        o_valid,
    input  logic        i_stall,
    input  t_data       o_median,
    input  logic        o_median_valid,
    input  logic [1:0]  o_status,
    input  logic [10:0] o_count,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_results,
    output int          o_full_hits,
    output int          o_absent_hits,
    output int          o_peak_count
);

    typedef struct {
        t_data   median;
        logic    median_valid;
        t_status status;
        t_cnt    count;
    } t_median_result;

    // ascending copy of the held values, only the first held_cnt are live
    t_data          sorted_vals [CAPACITY];
    int             held_cnt = 0;
    t_median_result expected_medians [$];

    initial begin
        o_fail_count  = 0;
        o_pending     = 0;
        o_results     = 0;
        o_full_hits   = 0;
        o_absent_hits = 0;
        o_peak_count  = 0;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t ns: mismatch on %s: got %0d expected %0d", $time, what, got, want);
        o_fail_count++;
    endtask

    // apply one insert or delete to the sorted copy and work out the median
    function automatic t_median_result apply_update(input t_action act, input t_data val);
        t_median_result         r;
        int                     pos;
        int                     k;
        logic signed [DATA_W:0] pair_sum;
        r.status = ST_OK;
        if (act == ACT_INSERT) begin
            if (held_cnt >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                pos = 0;
                while (pos < held_cnt && sorted_vals[pos] <= val) pos++;
                for (k = held_cnt; k > pos; k--) sorted_vals[k] = sorted_vals[k-1];
                sorted_vals[pos] = val;
                held_cnt++;
            end
        end else begin
            pos = 0;
            while (pos < held_cnt && sorted_vals[pos] != val) pos++;
            if (pos >= held_cnt) begin
                r.status = ST_ABSENT;
            end else begin
                for (k = pos; k + 1 < held_cnt; k++) sorted_vals[k] = sorted_vals[k+1];
                held_cnt--;
            end
        end
        // odd count takes the middle, even count the floor of the pair mean
        r.median       = '0;
        r.median_valid = (held_cnt > 0);
        if (held_cnt % 2 == 1) begin
            r.median = sorted_vals[(held_cnt - 1) / 2];
        end else if (held_cnt > 0) begin
            pair_sum = {sorted_vals[held_cnt/2 - 1][DATA_W-1], sorted_vals[held_cnt/2 - 1]}
                     + {sorted_vals[held_cnt/2][DATA_W-1], sorted_vals[held_cnt/2]};
            r.median = pair_sum[DATA_W:1];
        end
        r.count = t_cnt'(held_cnt);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_median_result want;
        if (!i_rst_n) begin
            held_cnt = 0;
            expected_medians.delete();
            o_pending = 0;
        end else begin
            // result beat against the oldest expectation
            if (o_valid && !i_stall) begin
                o_results++;
                if (expected_medians.size() == 0) begin
                    report_mismatch("result beat with nothing pending", o_median, 0);
                end else begin
                    want = expected_medians.pop_front();
                    if (o_median !== want.median)
                        report_mismatch("median", o_median, want.median);
                    if (o_median_valid !== want.median_valid)
                        report_mismatch("median_valid", o_median_valid, want.median_valid);
                    if (o_status !== want.status)
                        report_mismatch("status", o_status, want.status);
                    if (o_count !== want.count)
                        report_mismatch("count", o_count, want.count);
                end
            end
            // input beat updates the prediction
            if (i_valid && !o_stall) begin
                want = apply_update(t_action'(i_action), i_value);
                expected_medians.insert(expected_medians.size(), want);
                if (want.status == ST_FULL) o_full_hits++;
                if (want.status == ST_ABSENT) o_absent_hits++;
                if (held_cnt > o_peak_count) o_peak_count = held_cnt;
            end
            o_pending = expected_medians.size();
        end
    end

endmodule

/* dv/running_median_insert_delete_test.sv */
`timescale 1ns / 1ps

module running_median_insert_delete_test;
    import rmed_pkg::*;

    localparam int    CYCLE_LIMIT  = 400_000;
    localparam int    HOLD_CYCLES  = 120;
    localparam int    HOLD_SPACING = 600;
    localparam t_data MIN_V        = 32'sh8000_0000;
    localparam t_data MAX_V        = 32'sh7fff_ffff;

    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       i_valid        = 1'b0;
    t_action    i_action       = ACT_INSERT;
    t_data      i_value        = '0;
    logic       i_stall        = 1'b0;
    logic       o_stall;
    logic       o_valid;
    t_data      o_median;
    logic       o_median_valid;
    logic [1:0] o_status;
    logic [10:0] o_count;

    int o_fail_count;
    int o_pending;
    int o_results;
    int o_full_hits;
    int o_absent_hits;
    int o_peak_count;

    int send_idle_pct  = 8;
    int recv_idle_pct  = 63;
    int cycle_count    = 0;
    int beats_in       = 0;
    int hold_left      = 0;
    int next_hold_mark = 150;

    // values the block should hold right now, used to pick delete targets
    t_data held_vals [$];

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    running_median_insert_delete dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_action       (i_action),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_median       (o_median),
        .o_median_valid (o_median_valid),
        .o_status       (o_status),
        .o_count        (o_count)
    );

    running_median_checker u_scoreboard (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_action       (i_action),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_median       (o_median),
        .o_median_valid (o_median_valid),
        .o_status       (o_status),
        .o_count        (o_count),
        .o_fail_count   (o_fail_count),
        .o_pending      (o_pending),
        .o_results      (o_results),
        .o_full_hits    (o_full_hits),
        .o_absent_hits  (o_absent_hits),
        .o_peak_count   (o_peak_count)
    );

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side: random stall, plus a long hold-off every so many input beats
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) beats_in++;
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else if (beats_in >= next_hold_mark) begin
            i_stall <= 1'b1;
            hold_left = HOLD_CYCLES;
            next_hold_mark += HOLD_SPACING;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // offer one beat and wait until it is taken
    task automatic send_beat(input t_action act, input t_data val);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_action <= act;
        i_value  <= val;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic issue_op(input t_action act, input t_data val);
        int idx;
        if (act == ACT_INSERT) begin
            if (held_vals.size() < CAPACITY) held_vals.insert(held_vals.size(), val);
        end else begin
            idx = -1;
            foreach (held_vals[k]) if (idx < 0 && held_vals[k] == val) idx = k;
            if (idx >= 0) held_vals.delete(idx);
        end
        send_beat(act, val);
    endtask

    // small range for duplicates, corners, or anything
    function automatic t_data pick_value();
        int sel;
        sel = $urandom_range(99);
        if (sel < 30) return t_data'($signed($urandom_range(16)) - 8);
        if (sel < 40) begin
            case ($urandom_range(5))
                0: return MIN_V;
                1: return MIN_V + 1;
                2: return -1;
                3: return 0;
                4: return MAX_V - 1;
                default: return MAX_V;
            endcase
        end
        return t_data'($urandom);
    endfunction

    // insert at the given percentage, else mostly delete something held, otherwise a value that is likely absent
    task automatic random_op(input int insert_pct);
        if ($urandom_range(99) < insert_pct) begin
            issue_op(ACT_INSERT, pick_value());
        end else if (held_vals.size() > 0 && $urandom_range(99) < 85) begin
            issue_op(ACT_DELETE, held_vals[$urandom_range(held_vals.size() - 1)]);
        end else begin
            issue_op(ACT_DELETE, pick_value());
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty store, extremes, even-count overflow, duplicates
        issue_op(ACT_DELETE, 0);
        issue_op(ACT_INSERT, MAX_V);
        issue_op(ACT_INSERT, MIN_V);
        issue_op(ACT_INSERT, MAX_V);
        issue_op(ACT_INSERT, MAX_V);
        issue_op(ACT_DELETE, MAX_V);
        issue_op(ACT_DELETE, 12345);
        issue_op(ACT_DELETE, MAX_V);
        issue_op(ACT_DELETE, MAX_V);
        issue_op(ACT_INSERT, MIN_V);
        issue_op(ACT_INSERT, -1);
        issue_op(ACT_INSERT, 0);
        issue_op(ACT_INSERT, 5);
        issue_op(ACT_INSERT, 5);
        issue_op(ACT_INSERT, 5);
        issue_op(ACT_DELETE, 5);
        while (held_vals.size() > 0) issue_op(ACT_DELETE, held_vals[0]);
        issue_op(ACT_DELETE, MIN_V);

        // balanced mix around a small store
        repeat (200) random_op(55);

        // fill to capacity, then probe the full store
        send_idle_pct <= 63;
        recv_idle_pct <= 8;
        while (held_vals.size() < CAPACITY) random_op(97);
        repeat (20) random_op(60);

        // back-to-back, mostly deletes
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        repeat (150) random_op(35);
        i_valid <= 1'b0;

        // drain
        do @(posedge i_clk); while (o_pending != 0);
        repeat (16) @(posedge i_clk);

        $display("%0d result beats checked, peak store count %0d of %0d",
                 o_results, o_peak_count, CAPACITY);
        $display("%0d inserts into a full store, %0d deletes of absent values",
                 o_full_hits, o_absent_hits);
        if (o_fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches", o_fail_count);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
